// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
// Depends on nothing; each file that asserts includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is low.
`define B2D_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion that an expression never holds outside reset.
`define B2D_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== hw/rtl/b2d_pkg.sv =====
// Package of the binary to decimal ASCII converter: widths, defaults and state types.
// Depends on nothing; used by every module of the block.
package b2d_pkg;

  localparam int unsigned HALF_BITS       = 64;
  localparam int unsigned FULL_BITS       = 2 * HALF_BITS;
  localparam int unsigned CHAR_BITS       = 6;
  localparam int unsigned BCD_BITS        = 4;
  localparam int unsigned VALUE_BITS_DEF  = 128;
  localparam int unsigned DIGITS_DEF      = 39;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);
  localparam logic [BCD_BITS-1:0]  BCD_FIVE   = BCD_BITS'(5);
  localparam logic [BCD_BITS-1:0]  BCD_TEN    = BCD_BITS'(10);

  typedef logic [BCD_BITS-1:0] bcd_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_RUN,
    CONV_DONE
  } conv_state_e;

  typedef enum logic [1:0] {
    EMIT_IDLE,
    EMIT_SKIP,
    EMIT_SEND
  } emit_state_e;

endpackage

// ===== hw/rtl/b2d_value_if.sv =====
// Input channel of the converter: one 128-bit value as two 64-bit halves.
// Depends on b2d_pkg for the half width.
interface b2d_value_if import b2d_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [HALF_BITS-1:0] value_high;
  logic [HALF_BITS-1:0] value_low;

  modport source (output valid, output value_high, output value_low, input ready);
  modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

// ===== hw/rtl/b2d_digit_if.sv =====
// Output channel of the converter: one ASCII digit and its last flag per beat.
// Depends on b2d_pkg for the character width.
interface b2d_digit_if import b2d_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== hw/rtl/b2d_convert.sv =====
// Double dabble core: shifts the value in one bit per cycle into a row of BCD cells.
// Depends on b2d_pkg and the b2d_value_if interface.
module b2d_convert import b2d_pkg::*; #(
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF,
  parameter int unsigned DECIMAL_DIGITS = DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  b2d_value_if.sink           in_i,
  output bcd_t                digits_o [DECIMAL_DIGITS],
  output logic                done_o,
  input  logic                take_i
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  conv_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  bcd_t                  bcd_q [DECIMAL_DIGITS];
  bcd_t                  bcd_d [DECIMAL_DIGITS];
  logic [FULL_BITS-1:0]  full_value;
  logic                  accept;

  assign full_value = {in_i.value_high, in_i.value_low};
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CONV_IDLE: if (in_i.valid) state_d = CONV_RUN;
      CONV_RUN:  if (cnt_q == CNT_W'(1)) state_d = CONV_DONE;
      CONV_DONE: if (take_i) state_d = CONV_IDLE;
      default:   state_d = CONV_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    done_o     = 1'b0;
    unique case (state_q)
      CONV_IDLE: in_i.ready = 1'b1;
      CONV_DONE: done_o     = 1'b1;
      default: ;
    endcase
  end

  // Each cell doubles its digit and takes the carry of the cell below.
  always_comb begin
    logic       cin;
    logic [3:0] twice;
    cin   = 1'b0;
    twice = '0;
    val_d = val_q;
    cnt_d = cnt_q;
    for (int k = 0; k < DECIMAL_DIGITS; k++) begin
      bcd_d[k] = bcd_q[k];
    end
    if (accept) begin
      val_d = full_value[VALUE_BITS-1:0];
      cnt_d = CNT_W'(VALUE_BITS);
      for (int k = 0; k < DECIMAL_DIGITS; k++) begin
        bcd_d[k] = '0;
      end
    end else if (state_q == CONV_RUN) begin
      val_d = val_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      for (int k = 0; k < DECIMAL_DIGITS; k++) begin
        cin   = (k == 0) ? val_q[VALUE_BITS-1] : (bcd_q[(k == 0) ? 0 : k-1] >= BCD_FIVE);
        twice = {bcd_q[k][2:0], cin};
        bcd_d[k] = (bcd_q[k] >= BCD_FIVE) ? twice - BCD_TEN : twice;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CONV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cnt_q <= cnt_d;
    for (int k = 0; k < DECIMAL_DIGITS; k++) begin
      bcd_q[k] <= bcd_d[k];
    end
  end

  always_comb begin
    for (int k = 0; k < DECIMAL_DIGITS; k++) begin
      digits_o[k] = bcd_q[k];
    end
  end

endmodule

// ===== hw/rtl/b2d_emit.sv =====
// Digit output stage: drops leading zeros and sends ASCII digits most significant first.
// Depends on b2d_pkg and the b2d_digit_if interface.
module b2d_emit import b2d_pkg::*; #(
  parameter int unsigned DECIMAL_DIGITS = DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcd_t                digits_i [DECIMAL_DIGITS],
  input  logic                done_i,
  output logic                take_o,
  b2d_digit_if.source         out_o
);

  localparam int unsigned REM_W = $clog2(DECIMAL_DIGITS + 1);

  emit_state_e      state_q, state_d;
  bcd_t             dig_q [DECIMAL_DIGITS];
  bcd_t             dig_d [DECIMAL_DIGITS];
  logic [REM_W-1:0] rem_q, rem_d;
  bcd_t             top_digit;
  logic             one_left;
  logic             take;
  logic             shift;

  assign top_digit = dig_q[DECIMAL_DIGITS-1];
  assign one_left  = (rem_q == REM_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EMIT_IDLE: if (done_i) state_d = EMIT_SKIP;
      EMIT_SKIP: if (top_digit != '0 || one_left) state_d = EMIT_SEND;
      EMIT_SEND: if (out_o.ready && one_left) state_d = EMIT_IDLE;
      default:   state_d = EMIT_IDLE;
    endcase
  end

  always_comb begin
    take_o      = 1'b0;
    out_o.valid = 1'b0;
    shift       = 1'b0;
    unique case (state_q)
      EMIT_IDLE: take_o      = 1'b1;
      EMIT_SKIP: shift       = (top_digit == '0) && !one_left;
      EMIT_SEND: begin
        out_o.valid = 1'b1;
        shift       = out_o.ready && !one_left;
      end
      default: ;
    endcase
  end

  assign take             = take_o && done_i;
  assign out_o.digit_char = ASCII_ZERO + CHAR_BITS'(top_digit);
  assign out_o.last_digit = one_left;

  always_comb begin
    rem_d = rem_q;
    for (int k = 0; k < DECIMAL_DIGITS; k++) begin
      dig_d[k] = dig_q[k];
    end
    if (take) begin
      rem_d = REM_W'(DECIMAL_DIGITS);
      for (int k = 0; k < DECIMAL_DIGITS; k++) begin
        dig_d[k] = digits_i[k];
      end
    end else if (shift) begin
      rem_d    = rem_q - REM_W'(1);
      dig_d[0] = '0;
      for (int k = 1; k < DECIMAL_DIGITS; k++) begin
        dig_d[k] = dig_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EMIT_IDLE;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DECIMAL_DIGITS; k++) begin
      dig_q[k] <= dig_d[k];
    end
  end

endmodule

// ===== hw/rtl/binary128_to_decimal_ascii_unit.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on b2d_pkg, b2d_value_if, b2d_digit_if, b2d_convert and b2d_emit.
//
// Converts an unsigned VALUE_BITS-bit value (the low bits of value_high:value_low)
// into decimal ASCII digits, most significant first, leading zeros dropped, with
// last_digit set on the final beat; zero gives the single digit '0'. Values that
// need more than DECIMAL_DIGITS digits come out modulo 10^DECIMAL_DIGITS. The
// double dabble core takes one input bit per cycle and then holds its digits
// until the output stage, when idle, takes them. The output stage first drops
// the leading zeros, then sends the digit beats, each held while the output is
// not ready. The core accepts the next value in the cycle after its result has
// moved to the output stage; a stalled output keeps the finished result in the
// core and so stalls the input.
module binary128_to_decimal_ascii_unit import b2d_pkg::*; #(
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF,
  parameter int unsigned DECIMAL_DIGITS = DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b2d_value_if.sink   in_i,
  b2d_digit_if.source out_o
);

  bcd_t digits [DECIMAL_DIGITS];
  logic done;
  logic take;

  b2d_convert #(
    .VALUE_BITS     (VALUE_BITS),
    .DECIMAL_DIGITS (DECIMAL_DIGITS)
  ) u_convert (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .digits_o (digits),
    .done_o   (done),
    .take_i   (take)
  );

  b2d_emit #(
    .DECIMAL_DIGITS (DECIMAL_DIGITS)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .digits_i (digits),
    .done_i   (done),
    .take_o   (take),
    .out_o    (out_o)
  );

endmodule

// ===== hw/rtl/b2d_checker.sv =====
// Port-level checks of the converter, bound to its top level.
// Depends on b2d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b2d_checker import b2d_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [CHAR_BITS-1:0] out_digit_i,
  input logic                 out_last_i
);

  logic mid_q;
  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Set while the digits of a number are partly sent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (out_beat) begin
      mid_q <= !out_last_i;
    end
  end

  `B2D_ASSERT(out_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `B2D_ASSERT(digit_in_range, clk_i, rst_ni, out_valid_i |-> (out_digit_i >= ASCII_ZERO) && (out_digit_i <= ASCII_ZERO + CHAR_BITS'(9)))
  `B2D_ASSERT_NEVER(leading_zero_sent, clk_i, rst_ni, out_valid_i && !mid_q && !out_last_i && out_digit_i == ASCII_ZERO)
  `B2D_ASSERT(one_item_in_core, clk_i, rst_ni, in_beat |=> !in_ready_i)

endmodule

bind binary128_to_decimal_ascii_unit b2d_checker u_b2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_digit_i (out_o.digit_char),
  .out_last_i  (out_o.last_digit)
);

// ===== test/binary128_to_decimal_ascii_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for binary128_to_decimal_ascii_unit: drives 128-bit values, predicts
// the decimal ASCII digit beats and checks them in order. Depends on b2d_pkg,
// b2d_value_if, b2d_digit_if and the unit itself.
module binary128_to_decimal_ascii_unit_test;
  import b2d_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int HOLD_CYCLES = 700;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_ITEMS = 28;
  localparam int FILL_ITEMS  = 8;

  typedef struct packed {
    logic [HALF_BITS-1:0] value_high;
    logic [HALF_BITS-1:0] value_low;
  } value_beat_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } digit_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  b2d_value_if in_if ();
  b2d_digit_if out_if ();

  binary128_to_decimal_ascii_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  value_beat_t pending_values[$];
  digit_beat_t digits_due[$];
  int unsigned values_offered = 0;
  int unsigned values_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_seen = 0;
  int unsigned hold_left = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Splits the value into decimal digits and queues one beat per digit from the most
  // significant nonzero one down; zero leaves a single '0' beat.
  function automatic void predict_digits(logic [FULL_BITS-1:0] value);
    logic [FULL_BITS-1:0] rest;
    logic [BCD_BITS-1:0] digits [DIGITS_DEF];
    int top;
    digit_beat_t beat;
    rest = value;
    for (int k = DIGITS_DEF - 1; k >= 0; k--) begin
      digits[k] = BCD_BITS'(rest % 10);
      rest = rest / 10;
    end
    top = 0;
    while (top < DIGITS_DEF - 1 && digits[top] == 0) top++;
    for (int k = top; k < DIGITS_DEF; k++) begin
      beat.digit_char = CHAR_BITS'(ASCII_ZERO + digits[k]);
      beat.last_digit = (k == DIGITS_DEF - 1);
      digits_due.push_back(beat);
    end
  endfunction

  // Mostly values of random bit length, some near powers of ten, some small or full width.
  function automatic value_beat_t random_value();
    logic [FULL_BITS-1:0] value;
    logic [FULL_BITS-1:0] ten_pow;
    int bits;
    int unsigned pick;
    value = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      bits = $urandom_range(1, FULL_BITS);
      value = value & ({FULL_BITS{1'b1}} >> (FULL_BITS - bits));
      if ($urandom_range(0, 1) == 1) value[bits-1] = 1'b1;
    end else if (pick <= 7) begin
      ten_pow = FULL_BITS'(1);
      repeat ($urandom_range(0, DIGITS_DEF - 1)) ten_pow = ten_pow * FULL_BITS'(10);
      value = ten_pow + FULL_BITS'($urandom_range(0, 2)) - FULL_BITS'(1);
    end else if (pick == 9) begin
      value = FULL_BITS'($urandom_range(0, 1000));
    end
    return value_beat_t'(value);
  endfunction

  task automatic drain_all();
    while (pending_values.size() != 0 || values_taken != values_offered ||
           digits_due.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : value_driver
    value_beat_t next_value;
    logic next_valid;
    if (rst_ni) begin
      next_valid = in_if.valid;
      if (!in_if.valid || values_taken == values_offered) begin
        next_valid = 1'b0;
        if (pending_values.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_value = pending_values.pop_front();
          next_valid = 1'b1;
          values_offered++;
          in_if.value_high <= next_value.value_high;
          in_if.value_low <= next_value.value_low;
        end
      end
      in_if.valid <= next_valid;
    end
  end

  always @(negedge clk_i) begin : digit_receiver
    if (rst_ni) begin
      if (holds_seen != holds_requested) begin
        holds_seen = holds_requested;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : beat_checker
    digit_beat_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_digits({in_if.value_high, in_if.value_low});
        values_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (digits_due.size() == 0) begin
          $error("digit beat with no digit expected: digit_char %0d, last_digit %0d",
                 out_if.digit_char, out_if.last_digit);
          mismatches++;
        end else begin
          want = digits_due.pop_front();
          if (out_if.digit_char !== want.digit_char) begin
            $error("digit_char: expected %0d, actual %0d", want.digit_char, out_if.digit_char);
            mismatches++;
          end
          if (out_if.last_digit !== want.last_digit) begin
            $error("last_digit: expected %0d, actual %0d", want.last_digit, out_if.last_digit);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FULL_BITS-1:0] ten_pow;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.value_high = '0;
    in_if.value_low = '0;
    out_if.ready = 1'b0;
    tx_idle_pct = 14;
    rx_idle_pct = 62;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    pending_values.push_back(value_beat_t'(128'd0));
    pending_values.push_back(value_beat_t'(128'd1));
    pending_values.push_back(value_beat_t'(128'd9));
    pending_values.push_back(value_beat_t'(128'd10));
    pending_values.push_back(value_beat_t'(128'd99));
    pending_values.push_back(value_beat_t'(128'd100));
    pending_values.push_back(value_beat_t'(128'd12345));
    pending_values.push_back(value_beat_t'({64'd0, {64{1'b1}}}));
    pending_values.push_back(value_beat_t'({64'd1, 64'd0}));
    pending_values.push_back(value_beat_t'({{64{1'b1}}, 64'd0}));
    pending_values.push_back(value_beat_t'({1'b1, 127'd0}));
    pending_values.push_back(value_beat_t'({FULL_BITS{1'b1}}));
    pending_values.push_back(value_beat_t'({32{4'h5}}));
    pending_values.push_back(value_beat_t'({32{4'hA}}));
    ten_pow = FULL_BITS'(1);
    repeat (19) ten_pow = ten_pow * FULL_BITS'(10);
    pending_values.push_back(value_beat_t'(ten_pow - FULL_BITS'(1)));
    pending_values.push_back(value_beat_t'(ten_pow));
    repeat (19) ten_pow = ten_pow * FULL_BITS'(10);
    pending_values.push_back(value_beat_t'(ten_pow - FULL_BITS'(1)));
    pending_values.push_back(value_beat_t'(ten_pow));
    drain_all();

    // The output side stalls while values keep coming, so the unit backs up to its input.
    holds_requested++;
    repeat (FILL_ITEMS) pending_values.push_back(random_value());
    drain_all();

    repeat (PHASE_ITEMS) pending_values.push_back(random_value());
    drain_all();

    tx_idle_pct = 62;
    rx_idle_pct = 14;
    repeat (PHASE_ITEMS) pending_values.push_back(random_value());
    drain_all();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (PHASE_ITEMS) pending_values.push_back(random_value());
    drain_all();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && digits_due.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
